FILE: rtl/joint_slew_rate_and_range_limiter_core_macros.svh
// Assertion macros shared by the limiter RTL.
`ifndef JOINT_SLEW_RATE_AND_RANGE_LIMITER_CORE_MACROS_SVH
`define JOINT_SLEW_RATE_AND_RANGE_LIMITER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define JSRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define JSRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JSRL_ASSERT(lbl, prop, msg)
`define JSRL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/jsrl_pkg.sv
// Types, constants and helpers for the joint slew-rate and range limiter.
package jsrl_pkg;

  // Field widths.
  localparam int unsigned JointW  = 3;
  localparam int unsigned TargetW = 24;
  localparam int unsigned StepW   = 16;
  localparam int unsigned AngleW  = 17;
  localparam int unsigned CfgIdxW = 3;

  // Rate limit: 150 degrees per second is 15 hundredths of a degree per ms.
  localparam int unsigned RatePerMs = 15;
  localparam int unsigned LimitW    = StepW + 4;
  // Working width for target, previous angle and their difference.
  localparam int unsigned CalcW     = TargetW + 2;

  localparam int unsigned NumJointsDefault = 8;
  localparam int unsigned NumClasses       = 4;

  // Joint classes; each owns one min and one max register.
  typedef enum logic [1:0] {
    ClsShoulderRoll  = 2'd0,
    ClsElbowRoll     = 2'd1,
    ClsHead          = 2'd2,
    ClsShoulderPitch = 2'd3
  } jclass_e;

  // Configuration register index: class in the upper bits, max in bit 0.
  localparam int unsigned CfgMaxBit = 0;

  typedef logic signed [AngleW-1:0] angle_t;
  typedef angle_t bound_arr_t [NumClasses];

  // Reset values of the bounds, indexed by class.
  localparam bound_arr_t MinReset = '{-17'sd2000, -17'sd4500, -17'sd3500, -17'sd9000};
  localparam bound_arr_t MaxReset = '{17'sd9000, 17'sd9000, 17'sd3500, 17'sd18000};

  // One accepted input item.
  typedef struct packed {
    logic [JointW-1:0]         joint;
    logic signed [TargetW-1:0] target;
    logic [StepW-1:0]          step;
    logic                      first;
  } item_t;

  // Class of a joint index.
  function automatic jclass_e joint_class(input logic [JointW-1:0] joint);
    jclass_e cls;
    unique case (joint)
      3'd0, 3'd2: cls = ClsShoulderRoll;
      3'd1, 3'd3: cls = ClsElbowRoll;
      3'd4, 3'd5: cls = ClsHead;
      default:    cls = ClsShoulderPitch;
    endcase
    return cls;
  endfunction

endpackage

FILE: rtl/joint_slew_rate_and_range_limiter_core.sv
// Joint slew-rate and range limiter: top level.
//
// Usage: one input item carries a joint index, a target angle in hundredths
// of a degree, the step since that joint's previous sample in milliseconds
// and a first-sample flag. Unless the item is a first sample, the change from
// the joint's last limited angle is clamped to 15 hundredths per millisecond;
// the angle is then clamped to the bounds of the joint's class and stored.
// Both channels transfer on valid high and stall low. An item is captured in
// an input register, and the limiting logic between that register and the
// result register updates the joint's stored angle in the same edge that
// loads the result, so a following item for the same joint sees it.
// An item passes through the input register and then the result register;
// throughput is one item per cycle while the receiver does not stall, set
// by the single compute stage. When the receiver stalls, the result
// register holds its payload and the input register refills only once the
// result register frees up, so the input stalls after at most one more
// item. Reset empties both stages, clears every stored angle to zero and loads
// the default bounds. The user must see that bounds are written through the
// configuration port only while the block is idle; the block does not check.
module joint_slew_rate_and_range_limiter_core
  import jsrl_pkg::*;
#(
  parameter int unsigned NUM_JOINTS = NumJointsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration writes
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_addr_i,
  input  logic [AngleW-1:0]         cfg_wdata_i,
  // Input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [JointW-1:0]         joint_i,
  input  logic signed [TargetW-1:0] target_angle_i,
  input  logic [StepW-1:0]          step_ms_i,
  input  logic                      first_i,
  // Output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [JointW-1:0]         joint_out_o,
  output logic signed [AngleW-1:0]  limited_angle_o
);

  `include "joint_slew_rate_and_range_limiter_core_macros.svh"

  localparam int unsigned JIdxW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int unsigned ExtW  = JIdxW + JointW;
  localparam logic [4:0]  NumJointsV = 5'(NUM_JOINTS);

  // Bound registers, split by min and max so each is read at one class.
  angle_t min_q [NumClasses];
  angle_t max_q [NumClasses];
  // Last limited angle per joint.
  angle_t last_q [NUM_JOINTS];

  item_t                    s1_q;
  logic                     s1_valid_q;
  logic                     out_valid_q;
  logic [JointW-1:0]        out_joint_q;
  angle_t                   out_angle_q;

  logic                     in_xfer;
  logic                     s1_fire;
  logic [ExtW-1:0]          joint_ext;
  logic [JIdxW-1:0]         idx;
  logic                     joint_ok;
  jclass_e                  cls;
  logic [1:0]               cfg_cls;

  angle_t                   prev;
  angle_t                   lo;
  angle_t                   hi;
  logic [LimitW-1:0]        limit;
  logic signed [CalcW-1:0]  limit_w;
  logic signed [CalcW-1:0]  target_w;
  logic signed [CalcW-1:0]  prev_w;
  logic signed [CalcW-1:0]  delta;
  logic signed [CalcW-1:0]  rated;
  logic signed [CalcW-1:0]  above_lo;
  logic signed [CalcW-1:0]  clamped;
  angle_t                   angle_d;

  // Handshake: the compute stage moves on when the result register is free.
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= '{joint: joint_i, target: target_angle_i, step: step_ms_i, first: first_i};
    end
  end

  // Joint lookup and class selection.
  assign joint_ext = ExtW'(s1_q.joint);
  assign idx       = joint_ext[JIdxW-1:0];
  assign joint_ok  = {2'b00, s1_q.joint} < NumJointsV;
  assign cls       = joint_class(s1_q.joint);
  assign prev      = last_q[idx];
  assign lo        = min_q[cls];
  assign hi        = max_q[cls];

  // Slew limit: step times 15 as a shift and subtract.
  assign limit    = {s1_q.step, 4'b0000} - LimitW'(s1_q.step);
  assign limit_w  = signed'(CalcW'(limit));
  assign target_w = CalcW'(s1_q.target);
  assign prev_w   = CalcW'(prev);
  assign delta    = target_w - prev_w;

  always_comb begin
    rated = target_w;
    if (joint_ok && !s1_q.first) begin
      priority if (delta > limit_w) begin
        rated = prev_w + limit_w;
      end else if (delta < -limit_w) begin
        rated = prev_w - limit_w;
      end
    end
  end

  // Range clamp: minimum first, then maximum, so the maximum wins.
  assign above_lo = (rated < CalcW'(lo)) ? CalcW'(lo) : rated;
  assign clamped  = (above_lo > CalcW'(hi)) ? CalcW'(hi) : above_lo;
  assign angle_d  = clamped[AngleW-1:0];

  // Joint state, updated as the result is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        last_q[i] <= '0;
      end
    end else if (s1_fire && joint_ok) begin
      last_q[idx] <= angle_d;
    end
  end

  // Bound registers.
  assign cfg_cls = cfg_addr_i[CfgIdxW-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinReset;
      max_q <= MaxReset;
    end else if (cfg_we_i) begin
      if (cfg_addr_i[CfgMaxBit]) begin
        max_q[cfg_cls] <= cfg_wdata_i;
      end else begin
        min_q[cfg_cls] <= cfg_wdata_i;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_joint_q <= s1_q.joint;
      out_angle_q <= angle_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign joint_out_o     = out_joint_q;
  assign limited_angle_o = out_angle_q;

  // Assertions.
  `JSRL_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> s1_valid_q, "input stalled while empty")
  `JSRL_ASSERT(a_fire_loads_result, s1_fire |=> out_valid_q, "item lost in compute stage")
  `JSRL_ASSERT(a_state_matches_result, s1_fire && joint_ok |=> last_q[$past(idx)] == out_angle_q, "stored angle differs from result")

endmodule

FILE: tb/sv/jsrl_limit_checker.sv
// Checker for the joint limiter: predicts each limited angle and compares the results.
`timescale 1ns / 1ps

module jsrl_limit_checker
  import jsrl_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_addr_i,
  input  logic [AngleW-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_o,
  input  logic [JointW-1:0]         joint_i,
  input  logic signed [TargetW-1:0] target_angle_i,
  input  logic [StepW-1:0]          step_ms_i,
  input  logic                      first_i,
  input  logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  logic [JointW-1:0]         joint_out_o,
  input  logic signed [AngleW-1:0]  limited_angle_o,
  output int                        fail_count_o,
  output int                        pending_o
);

  // One limited sample as the block should emit it.
  typedef struct {
    logic [JointW-1:0] joint;
    angle_t            angle;
  } limited_sample_t;

  // Mirror of the block's bounds and per-joint angle memory.
  angle_t bound_lo [NumClasses];
  angle_t bound_hi [NumClasses];
  angle_t joint_angle [NumJointsDefault];

  limited_sample_t expected_angle_q [$];
  limited_sample_t want;
  limited_sample_t predicted;
  item_t           sample;
  angle_t          angle;

  // Joints pair up into four classes: roll, elbow, head and pitch.
  function automatic jclass_e class_of_joint(input logic [JointW-1:0] joint);
    if (joint[2]) begin
      return joint[1] ? ClsShoulderPitch : ClsHead;
    end
    return joint[0] ? ClsElbowRoll : ClsShoulderRoll;
  endfunction

  // Rate clamp against the joint's last angle, then the class range clamp.
  // The minimum is applied first, so the maximum wins when the two cross.
  function automatic angle_t predict_limited_angle(input item_t it);
    longint  target;
    longint  prev;
    longint  limit;
    longint  x;
    jclass_e cls;
    cls    = class_of_joint(it.joint);
    target = it.target;
    prev   = joint_angle[it.joint];
    limit  = it.step;
    limit  = limit * longint'(RatePerMs);
    x      = target;
    if (!it.first) begin
      if (target - prev > limit) begin
        x = prev + limit;
      end else if (target - prev < -limit) begin
        x = prev - limit;
      end
    end
    if (x < longint'(bound_lo[cls])) begin
      x = bound_lo[cls];
    end
    if (x > longint'(bound_hi[cls])) begin
      x = bound_hi[cls];
    end
    return angle_t'(x);
  endfunction

  // Track configuration writes, check each output transfer against the oldest
  // prediction, and predict each input transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumClasses; c++) begin
        bound_lo[c] = MinReset[c];
        bound_hi[c] = MaxReset[c];
      end
      for (int j = 0; j < NumJointsDefault; j++) begin
        joint_angle[j] = '0;
      end
      expected_angle_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i[CfgMaxBit]) begin
          bound_hi[jclass_e'(cfg_addr_i >> 1)] = cfg_wdata_i;
        end else begin
          bound_lo[jclass_e'(cfg_addr_i >> 1)] = cfg_wdata_i;
        end
      end

      if (out_valid_o && !out_stall_i) begin
        if (expected_angle_q.size() == 0) begin
          $error("unexpected result: joint_out %0d, limited_angle %0d",
                 joint_out_o, limited_angle_o);
          fail_count_o++;
        end else begin
          want = expected_angle_q.pop_front();
          if (joint_out_o !== want.joint) begin
            $error("joint_out: expected %0d, actual %0d", want.joint, joint_out_o);
            fail_count_o++;
          end
          if (limited_angle_o !== want.angle) begin
            $error("limited_angle: expected %0d, actual %0d", want.angle, limited_angle_o);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_o) begin
        sample = '{joint: joint_i, target: target_angle_i, step: step_ms_i, first: first_i};
        angle  = predict_limited_angle(sample);
        joint_angle[sample.joint] = angle;
        predicted.joint = sample.joint;
        predicted.angle = angle;
        expected_angle_q.insert(expected_angle_q.size(), predicted);
      end

      pending_o = expected_angle_q.size();
    end
  end

endmodule

FILE: tb/sv/joint_slew_rate_and_range_limiter_core_tb.sv
// Testbench top for the joint limiter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module joint_slew_rate_and_range_limiter_core_tb;
  import jsrl_pkg::*;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_addr_i;
  logic [AngleW-1:0]         cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [JointW-1:0]         joint_i;
  logic signed [TargetW-1:0] target_angle_i;
  logic [StepW-1:0]          step_ms_i;
  logic                      first_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [JointW-1:0]         joint_out_o;
  logic signed [AngleW-1:0]  limited_angle_o;

  int fail_count;
  int pending;

  // Flow control knobs for the sender and the receiver.
  bit tx_idle_en    = 1'b0;
  bit rx_idle_en    = 1'b0;
  bit long_hold_req = 1'b0;

  localparam int LongHoldCycles = 120;

  joint_slew_rate_and_range_limiter_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .joint_i        (joint_i),
    .target_angle_i (target_angle_i),
    .step_ms_i      (step_ms_i),
    .first_i        (first_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .joint_out_o    (joint_out_o),
    .limited_angle_o(limited_angle_o)
  );

  jsrl_limit_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .joint_i        (joint_i),
    .target_angle_i (target_angle_i),
    .step_ms_i      (step_ms_i),
    .first_i        (first_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .joint_out_o    (joint_out_o),
    .limited_angle_o(limited_angle_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #2 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one sample and hold it until the block takes the transfer.
  task automatic send_sample(input logic [JointW-1:0] joint,
                             input logic signed [TargetW-1:0] target,
                             input logic [StepW-1:0] step, input logic fst);
    in_valid_i     <= 1'b1;
    joint_i        <= joint;
    target_angle_i <= target;
    step_ms_i      <= step;
    first_i        <= fst;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sender gap of a random length, only now and then.
  task automatic maybe_gap();
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Mostly short steps and targets within +-40000, with full-range noise mixed in.
  task automatic send_random_sample();
    logic signed [TargetW-1:0] target;
    logic [StepW-1:0]          step;
    case ($urandom_range(0, 9))
      0:       target = TargetW'($urandom);
      1:       target = $urandom_range(0, 1) ? {1'b0, {(TargetW-1){1'b1}}}
                                             : {1'b1, {(TargetW-1){1'b0}}};
      default: target = TargetW'(int'($urandom_range(0, 80000)) - 40000);
    endcase
    case ($urandom_range(0, 7))
      0:       step = '0;
      1:       step = StepW'($urandom);
      2:       step = '1;
      default: step = StepW'($urandom_range(1, 200));
    endcase
    send_sample(JointW'($urandom_range(0, 7)), target, step, $urandom_range(0, 11) == 0);
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write the min and max of every class; the register index is {class, is_max}.
  task automatic load_bounds(input bound_arr_t lo, input bound_arr_t hi);
    for (int c = 0; c < NumClasses; c++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= {jclass_e'(c), 1'b0};
      cfg_wdata_i <= lo[c];
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= {jclass_e'(c), 1'b1};
      cfg_wdata_i <= hi[c];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    bound_arr_t lo;
    bound_arr_t hi;
    int         a;
    int         b;
    int         count;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    joint_i        = '0;
    target_angle_i = '0;
    step_ms_i      = '0;
    first_i        = 1'b0;
    rst_ni         = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples under the reset bounds: target extremes, zero step,
    // largest step, exact rate limit, and every joint.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_sample(3'd0, 24'sh7FFFFF, 16'd0, 1'b1);
    send_sample(3'd1, -24'sh800000, 16'd0, 1'b1);
    send_sample(3'd2, 24'sd0, 16'd0, 1'b1);
    send_sample(3'd0, -24'sd100000, 16'd0, 1'b0);
    send_sample(3'd0, 24'sd0, 16'd10, 1'b0);
    send_sample(3'd0, -24'sh800000, 16'hFFFF, 1'b0);
    send_sample(3'd1, 24'sh7FFFFF, 16'd1, 1'b0);
    send_sample(3'd3, 24'sd500, 16'd100, 1'b0);
    send_sample(3'd4, 24'sd3500, 16'd7, 1'b1);
    send_sample(3'd4, -24'sd3500, 16'd2, 1'b0);
    send_sample(3'd5, 24'sh7FFFFF, 16'hFFFF, 1'b0);
    send_sample(3'd6, -24'sd9000, 16'd0, 1'b1);
    send_sample(3'd6, 24'sd18000, 16'd1000, 1'b0);
    send_sample(3'd7, 24'sd12345, 16'hFFFF, 1'b0);
    send_sample(3'd7, 24'sd0, 16'd0, 1'b0);
    send_sample(3'd2, -24'sd15, 16'd1, 1'b0);
    send_sample(3'd2, -24'sd31, 16'd1, 1'b0);
    send_sample(3'd3, -24'sd1, 16'hFFFF, 1'b1);
    send_sample(3'd5, -24'sh555556, 16'h5555, 1'b0);
    send_sample(3'd1, 24'sh2AAAAA, 16'hAAAA, 1'b0);

    // Random phases, each under its own bound setting.
    for (int phase = 1; phase <= 8; phase++) begin
      wait_drained();
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      for (int c = 0; c < NumClasses; c++) begin
        a = int'($urandom_range(0, 72000)) - 36000;
        b = int'($urandom_range(0, 72000)) - 36000;
        case (phase)
          1: begin
            a = -36000;
            b = 36000;
          end
          2: begin
            // Minimum above maximum, or equal, so the maximum wins.
            a = (c == ClsElbowRoll) ? 100 : 3000 - 1000 * c;
            b = (c == ClsElbowRoll) ? 100 : -3000 + 1000 * c;
          end
          3: begin
            // Outside the stated range: the full 17-bit span.
            a = -65536;
            b = 65535;
          end
          6: ;
          8: begin
            a = MinReset[c];
            b = MaxReset[c];
          end
          default: begin
            if (a > b) begin
              {a, b} = {b, a};
            end
          end
        endcase
        lo[c] = angle_t'(a);
        hi[c] = angle_t'(b);
      end
      load_bounds(lo, hi);

      if (phase == 4 || phase == 8) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (phase == 2) begin
        long_hold_req = 1'b1;
      end
      count = (phase == 8) ? 120 : 155;
      for (int k = 0; k < count; k++) begin
        if (phase == 5 && k == 80) begin
          wait_drained();
        end
        maybe_gap();
        send_random_sample();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
